// ----- rtl/core/mts_pkg.sv -----
// Package for the magnitude threshold symbol slicer.
// Types, constants and controller/datapath command structs. No dependencies.
package mts_pkg;
  localparam int MaxSymbolsDefault = 64;
  localparam int SampleBitsDefault = 16;
  localparam int LevelBits = 16;
  localparam logic CfgAlphabetMin = 1'b0;
  localparam logic CfgAlphabetMax = 1'b1;
  localparam logic signed [LevelBits-1:0] AlphabetMinReset = -16'sd3;
  localparam logic signed [LevelBits-1:0] AlphabetMaxReset = 16'sd3;

  typedef enum logic [2:0] {
    ST_LOAD, ST_EXT_LO, ST_EXT_HI, ST_READ, ST_SQRT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;       // store accepted sample
    logic clear;      // end of frame reset
    logic sqrt_start; // start root of selected operand
    logic sel_lo;     // operand: lowest point
    logic sel_hi;     // operand: highest point
    logic save_lo;    // capture root as threshold part
    logic save_hi;
    logic rd;         // read store at emit index
    logic out_load;   // register result
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic last_idx;
    logic empty;
  } status_t;
endpackage

// ----- rtl/core/magnitude_threshold_symbol_slicer.sv -----
// Channel   Handshake        Payload
// in        in_valid/ready   sample_real, sample_imag, frame_end
// out       out_valid/ready  quant_real, quant_imag, inner_ring, overflowed, result_last
// cfg       cfg_we           cfg_index, cfg_data
// Load takes one sample per cycle. After frame_end two threshold roots run,
// then each symbol in turn is read, squared and rooted by the two-bit-per-cycle root unit, then emitted.
// Synchronous reset; an output stall holds the emit pass, and input waits until
// the frame is emitted. Depends on mts_pkg, mts_ctrl, mts_datapath.
module magnitude_threshold_symbol_slicer import mts_pkg::*; #(
  parameter int MAX_SYMBOLS = MaxSymbolsDefault,
  parameter int SAMPLE_BITS = SampleBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_real,
  input  logic signed [SAMPLE_BITS-1:0] sample_imag,
  input  logic frame_end,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [LevelBits-1:0] quant_real,
  output logic signed [LevelBits-1:0] quant_imag,
  output logic inner_ring,
  output logic overflowed,
  output logic result_last,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [LevelBits-1:0] cfg_data
);
  cmd_t cmd;
  status_t status;
  logic in_fire, out_set;
  logic signed [LevelBits-1:0] lvl_min, lvl_max;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_min <= AlphabetMinReset; lvl_max <= AlphabetMaxReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgAlphabetMin: lvl_min <= cfg_data;
        CfgAlphabetMax: lvl_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_set) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  mts_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_end(frame_end), .out_busy(out_valid),
    .out_taken(out_ready), .status, .cmd, .in_rdy(in_ready), .out_set
  );

  mts_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst, .cmd, .status, .in_re(sample_real), .in_im(sample_imag),
    .lvl_min, .lvl_max, .q_re(quant_real), .q_im(quant_imag), .q_inner(inner_ring),
    .q_ovf(overflowed), .q_last(result_last)
  );
endmodule

// ----- rtl/core/mts_isqrt.sv -----
// Iterative integer square root, two result bits per cycle.
// Depends on mts_pkg.
module mts_isqrt import mts_pkg::*; #(
  parameter int W = 34
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [W-1:0] x,
  output logic done,
  output logic [W/2-1:0] root
);
  localparam int Steps = W / 2;
  localparam int CntBits = $clog2(Steps + 1);
  localparam int NumBits = W + 2;
  logic [NumBits-1:0] rem, bitv, res;
  logic [CntBits-1:0] cnt;
  logic busy;
  logic [NumBits-1:0] r1, b1, s1, r2, b2, x1, x2;

  always_comb begin
    x1 = rem; r1 = res; b1 = bitv;
    s1 = r1 + b1;
    if (x1 >= s1) begin
      x1 = x1 - s1; r1 = (r1 >> 1) + b1;
    end else begin
      r1 = r1 >> 1;
    end
    b1 = b1 >> 2;
    x2 = x1; r2 = r1; b2 = b1;
    s1 = r2 + b2;
    if (b2 != '0 && x2 >= s1) begin
      x2 = x2 - s1; r2 = (r2 >> 1) + b2;
    end else if (b2 != '0) begin
      r2 = r2 >> 1;
    end
    b2 = b2 >> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntBits'((Steps + 1) / 2);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= NumBits'(x);
      res <= '0;
      bitv <= NumBits'(1) << (2 * (((Steps + 1) / 2) * 2 - 1));
    end else if (busy) begin
      rem <= x2; res <= r2; bitv <= b2;
    end
  end

  assign root = res[W/2-1:0];
endmodule

// ----- rtl/core/mts_datapath.sv -----
// Datapath: symbol store, extreme tracking, threshold, slicing.
// Depends on mts_pkg and mts_isqrt.
module mts_datapath import mts_pkg::*; #(
  parameter int MAX_SYMBOLS = MaxSymbolsDefault,
  parameter int SAMPLE_BITS = SampleBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output status_t status,
  input  logic signed [SAMPLE_BITS-1:0] in_re,
  input  logic signed [SAMPLE_BITS-1:0] in_im,
  input  logic signed [LevelBits-1:0] lvl_min,
  input  logic signed [LevelBits-1:0] lvl_max,
  output logic signed [LevelBits-1:0] q_re,
  output logic signed [LevelBits-1:0] q_im,
  output logic q_inner,
  output logic q_ovf,
  output logic q_last
);
  localparam int AddrBits = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CntBits = $clog2(MAX_SYMBOLS + 1);
  localparam int SqW = 2 * SAMPLE_BITS + 2;
  localparam int RootW = SqW / 2;

  logic [2*SAMPLE_BITS-1:0] mem [MAX_SYMBOLS];
  logic [CntBits-1:0] count, idx;
  logic [AddrBits-1:0] rd_addr;
  logic full;
  logic signed [SAMPLE_BITS-1:0] lo_re, lo_im, hi_re, hi_im, rd_re, rd_im;
  logic ovf;
  logic [RootW:0] thresh;
  logic [RootW-1:0] root;
  logic signed [SAMPLE_BITS-1:0] op_re, op_im;
  logic signed [2*SAMPLE_BITS-1:0] pr, pi;
  logic [SqW-1:0] sq;
  logic sdone;
  logic signed [LevelBits-1:0] lvl, nlvl;
  logic inner;

  assign full = (count == CntBits'(MAX_SYMBOLS));

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0; ovf <= 1'b0; lo_re <= '0; lo_im <= '0; hi_re <= '0; hi_im <= '0;
    end else if (cmd.load) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        count <= count + 1'b1;
        if (count == '0 || in_re < lo_re || (in_re == lo_re && in_im < lo_im)) begin
          lo_re <= in_re; lo_im <= in_im;
        end
        if (count == '0 || in_re > hi_re || (in_re == hi_re && in_im > hi_im)) begin
          hi_re <= in_re; hi_im <= in_im;
        end
      end
    end
  end

  // next entry is fetched while the emit index advances
  assign rd_addr = idx[AddrBits-1:0] + AddrBits'(cmd.idx_inc);

  always_ff @(posedge clk) begin
    if (cmd.load && !full) mem[count[AddrBits-1:0]] <= {in_re, in_im};
    if (cmd.rd) {rd_re, rd_im} <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + 1'b1;
  end

  always_comb begin
    if (cmd.sel_lo) begin
      op_re = lo_re; op_im = lo_im;
    end else if (cmd.sel_hi) begin
      op_re = hi_re; op_im = hi_im;
    end else begin
      op_re = rd_re; op_im = rd_im;
    end
  end

  // squares are registered before the root unit starts
  always_ff @(posedge clk) begin
    pr <= op_re * op_re;
    pi <= op_im * op_im;
  end
  assign sq = SqW'(unsigned'(pr)) + SqW'(unsigned'(pi));

  mts_isqrt #(.W(SqW)) u_sqrt (
    .clk, .rst, .start(cmd.sqrt_start), .x(sq), .done(sdone), .root(root)
  );

  always_ff @(posedge clk) begin
    if (cmd.save_lo) thresh <= (RootW+1)'(root);
    else if (cmd.save_hi) thresh <= thresh + (RootW+1)'(root);
  end

  assign inner = ({root, 2'b00} < (RootW+2)'(thresh));
  assign lvl = inner ? lvl_min : lvl_max;
  assign nlvl = -lvl;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      q_re <= (rd_re == '0) ? '0 : (rd_re < 0 ? nlvl : lvl);
      q_im <= (rd_im == '0) ? '0 : (rd_im < 0 ? nlvl : lvl);
      q_inner <= inner;
      q_ovf <= ovf;
      q_last <= (idx + 1'b1 == count);
    end
  end

  assign status.sqrt_done = sdone;
  assign status.last_idx = (idx + 1'b1 == count);
  assign status.empty = (count == '0);
endmodule

// ----- rtl/core/mts_ctrl.sv -----
// Controller FSM sequencing load, threshold roots and emit pass.
// Depends on mts_pkg.
module mts_ctrl import mts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic in_end,
  input  logic out_busy,
  input  logic out_taken,
  input  status_t status,
  output cmd_t cmd,
  output logic in_rdy,
  output logic out_set
);
  state_t state, state_next;
  logic sq_go, sq_go_next; // squares ready next cycle
  logic arm, arm_next;     // lowest point squared this cycle

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD; sq_go <= 1'b0; arm <= 1'b0;
    end else begin
      state <= state_next; sq_go <= sq_go_next; arm <= arm_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (in_fire && in_end) state_next = ST_EXT_LO;
      ST_EXT_LO: if (status.sqrt_done) state_next = ST_EXT_HI;
      ST_EXT_HI: if (status.sqrt_done) state_next = status.empty ? ST_LOAD : ST_READ;
      ST_READ: state_next = ST_SQRT;
      ST_SQRT: if (status.sqrt_done) state_next = ST_EMIT;
      ST_EMIT: if (!out_busy || out_taken)
                 state_next = status.last_idx ? ST_LOAD : ST_READ;
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    sq_go_next = 1'b0;
    arm_next = 1'b0;
    in_rdy = 1'b0;
    out_set = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_rdy = 1'b1;
        cmd.load = in_fire;
        cmd.sel_lo = 1'b1;
        arm_next = in_fire && in_end;
      end
      ST_EXT_LO: begin
        cmd.sel_lo = arm;
        cmd.sel_hi = 1'b1;
        cmd.sqrt_start = sq_go;
        cmd.save_lo = status.sqrt_done;
        sq_go_next = arm || status.sqrt_done;
      end
      ST_EXT_HI: begin
        cmd.sqrt_start = sq_go;
        cmd.save_hi = status.sqrt_done;
        cmd.clear = status.sqrt_done && status.empty;
        cmd.rd = status.sqrt_done;
      end
      ST_READ: sq_go_next = 1'b1;
      ST_SQRT: cmd.sqrt_start = sq_go;
      ST_EMIT: begin
        if (!out_busy || out_taken) begin
          cmd.out_load = 1'b1;
          out_set = 1'b1;
          cmd.idx_inc = 1'b1;
          cmd.clear = status.last_idx;
          cmd.rd = 1'b1;
        end
      end
      default: ;
    endcase
    if (state == ST_EMIT && !(!out_busy || out_taken)) cmd.idx_inc = 1'b0;
  end
endmodule

// ----- rtl/core/mts_checker.sv -----
// Port-level checker for the slicer, bound to the top level.
// Depends on mts_pkg.
module mts_checker import mts_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic frame_end,
  input logic out_valid,
  input logic out_ready,
  input logic result_last
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_last) |-> !in_ready) else $error("input taken during emit");
  a_end_stops_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && frame_end) |=> !in_ready) else $error("ready after frame end");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(result_last))
    else $error("output dropped");
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("valid after reset");
endmodule

bind magnitude_threshold_symbol_slicer mts_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .frame_end, .out_valid, .out_ready, .result_last
);
